[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CNA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CNA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/cna_pkg.sv]
// ----------------------------------------------------------------------------
// cna_pkg
// Types, codes and helper functions shared by the complex ALU files.
// ----------------------------------------------------------------------------
`default_nettype none
package cna_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // Quotient bits kept by the divider; anything at or above 2^17 saturates.
    localparam int QUOT_BITS = 17;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
        logic               b_zero;
    } cna_item_t;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } cna_qstat_t;

    typedef struct packed {
        logic        sat;
        logic [15:0] val;
    } cna_part_t;

    // Magnitude of a 33-bit signed value.
    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

    // Clamp a sign and magnitude pair to the signed 16-bit range.
    function automatic cna_part_t clamp_part(input logic neg, input logic [32:0] mag);
        cna_part_t p;
        if (!neg) begin
            p.sat = (mag > 33'd32767);
            p.val = p.sat ? 16'h7fff : mag[15:0];
        end
        else begin
            p.sat = (mag > 33'd32768);
            p.val = p.sat ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

[rtl/cna_in_if.sv]
// ----------------------------------------------------------------------------
// cna_in_if
// Operand channel: valid/ready handshake with operation code and operands.
// ----------------------------------------------------------------------------
`default_nettype none
interface cna_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;

    modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

[rtl/cna_out_if.sv]
// ----------------------------------------------------------------------------
// cna_out_if
// Result channel: valid/ready handshake with result parts and status.
// ----------------------------------------------------------------------------
`default_nettype none
interface cna_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_re;
    logic signed [15:0] r_im;
    logic [1:0]         status;

    modport source (output valid, r_re, r_im, status, input ready);
    modport sink (input valid, r_re, r_im, status, output ready);
endinterface
`default_nettype wire

[rtl/cna_front.sv]
// ----------------------------------------------------------------------------
// cna_front
// Accepts operand transfers and tags each with a zero-divisor flag.
// ----------------------------------------------------------------------------
`default_nettype none
module cna_front (
    cna_in_if.sink              in_ch,
    input  cna_pkg::cna_qstat_t qstat,
    output cna_pkg::cna_item_t  item,
    output logic                push
);
    import cna_pkg::*;

    assign in_ch.ready = !qstat.full;
    assign push        = in_ch.valid && !qstat.full;

    always_comb
    begin
        item.func   = in_ch.func;
        item.a_re   = in_ch.a_re;
        item.a_im   = in_ch.a_im;
        item.b_re   = in_ch.b_re;
        item.b_im   = in_ch.b_im;
        item.b_zero = (in_ch.b_re == 16'sd0) && (in_ch.b_im == 16'sd0);
    end
endmodule
`default_nettype wire

[rtl/cna_queue.sv]
// ----------------------------------------------------------------------------
// cna_queue
// Short FIFO that decouples the front end from the execution pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module cna_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cna_pkg::cna_item_t  wr_item,
    input  logic                pop,
    output cna_pkg::cna_item_t  rd_item,
    output cna_pkg::cna_qstat_t qstat
);
    import cna_pkg::*;

    cna_item_t         mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item     = mem_reg[rd_ptr_reg];
    assign qstat.valid = (cnt_reg != '0);
    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.count = cnt_reg;
endmodule
`default_nettype wire

[rtl/cna_back.sv]
// ----------------------------------------------------------------------------
// cna_back
// Execution pipeline: products, sums, bit-per-stage divider, clamp, output.
// ----------------------------------------------------------------------------
`default_nettype none
module cna_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cna_pkg::cna_item_t item,
    input  logic               item_valid,
    output logic               pop,
    cna_out_if.source          out_ch
);
    import cna_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int QB = QUOT_BITS;
    localparam int CW = NW + QB;

    typedef struct packed {
        logic [1:0]    op;
        logic          b_zero;
        logic          e_neg_re;
        logic          e_neg_im;
        logic [32:0]   e_mag_re;
        logic [32:0]   e_mag_im;
        logic          d_neg_re;
        logic          d_neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [NW-1:0] rem_re;
        logic [NW-1:0] rem_im;
        logic [QB-1:0] quo_re;
        logic [QB-1:0] quo_im;
        logic [31:0]   den;
    } stage_t;

    logic en;

    // First stage: the six products and the add/subtract result.
    logic               s1_vld_reg;
    logic [1:0]         s1_op_reg;
    logic               s1_bz_reg;
    logic signed [31:0] s1_rr_reg;
    logic signed [31:0] s1_ii_reg;
    logic signed [31:0] s1_ri_reg;
    logic signed [31:0] s1_ir_reg;
    logic signed [31:0] s1_bbr_reg;
    logic signed [31:0] s1_bbi_reg;
    logic signed [16:0] s1_asre_reg;
    logic signed [16:0] s1_asim_reg;

    stage_t      stg_reg [0:QB];
    stage_t      stg_next [1:QB];
    logic [QB:0] vld_reg;
    stage_t      st0_next;

    logic               out_vld_reg;
    logic signed [15:0] out_re_reg;
    logic signed [15:0] out_im_reg;
    logic [1:0]         out_st_reg;

    logic [15:0] out_fin_re;
    logic [15:0] out_fin_im;
    logic [1:0]  out_fin_st;

    assign en  = !out_vld_reg || out_ch.ready;
    assign pop = en && item_valid;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg  <= item.func;
            s1_bz_reg  <= item.b_zero;
            s1_rr_reg  <= item.a_re * item.b_re;
            s1_ii_reg  <= item.a_im * item.b_im;
            s1_ri_reg  <= item.a_re * item.b_im;
            s1_ir_reg  <= item.a_im * item.b_re;
            s1_bbr_reg <= item.b_re * item.b_re;
            s1_bbi_reg <= item.b_im * item.b_im;
            if (item.func == OP_SUB)
            begin
                s1_asre_reg <= 17'(item.a_re) - 17'(item.b_re);
                s1_asim_reg <= 17'(item.a_im) - 17'(item.b_im);
            end
            else
            begin
                s1_asre_reg <= 17'(item.a_re) + 17'(item.b_re);
                s1_asim_reg <= 17'(item.a_im) + 17'(item.b_im);
            end
        end
    end

    // Second stage: sums, early results and the divider setup.
    always_comb
    begin
        logic signed [32:0] m_re;
        logic signed [32:0] m_im;
        logic signed [32:0] d_re;
        logic signed [32:0] d_im;
        logic [32:0]        dm_re;
        logic [32:0]        dm_im;
        m_re  = 33'(s1_rr_reg) - 33'(s1_ii_reg);
        m_im  = 33'(s1_ri_reg) + 33'(s1_ir_reg);
        d_re  = 33'(s1_rr_reg) + 33'(s1_ii_reg);
        d_im  = 33'(s1_ir_reg) - 33'(s1_ri_reg);
        dm_re = abs33(d_re);
        dm_im = abs33(d_im);
        st0_next.op     = s1_op_reg;
        st0_next.b_zero = s1_bz_reg;
        if (s1_op_reg == OP_MUL)
        begin
            st0_next.e_neg_re = m_re[32];
            st0_next.e_neg_im = m_im[32];
            st0_next.e_mag_re = abs33(m_re) >> FRAC_BITS;
            st0_next.e_mag_im = abs33(m_im) >> FRAC_BITS;
        end
        else
        begin
            st0_next.e_neg_re = s1_asre_reg[16];
            st0_next.e_neg_im = s1_asim_reg[16];
            st0_next.e_mag_re = abs33(33'(s1_asre_reg));
            st0_next.e_mag_im = abs33(33'(s1_asim_reg));
        end
        st0_next.d_neg_re = d_re[32];
        st0_next.d_neg_im = d_im[32];
        st0_next.den      = 32'($unsigned(s1_bbr_reg)) + 32'($unsigned(s1_bbi_reg));
        st0_next.rem_re   = NW'(dm_re[31:0]) << FRAC_BITS;
        st0_next.rem_im   = NW'(dm_im[31:0]) << FRAC_BITS;
        st0_next.ovf_re   = (st0_next.rem_re >> QB) >= NW'(st0_next.den);
        st0_next.ovf_im   = (st0_next.rem_im >> QB) >= NW'(st0_next.den);
        st0_next.quo_re   = '0;
        st0_next.quo_im   = '0;
    end

    // Restoring divider, one quotient bit per stage, both parts side by side.
    always_comb
    begin
        logic [CW-1:0] dsh;
        for (int k = 0; k < QB; k++)
        begin
            stg_next[k + 1] = stg_reg[k];
            dsh = CW'(stg_reg[k].den) << (QB - 1 - k);
            if (CW'(stg_reg[k].rem_re) >= dsh)
            begin
                stg_next[k + 1].rem_re             = stg_reg[k].rem_re - dsh[NW-1:0];
                stg_next[k + 1].quo_re[QB - 1 - k] = 1'b1;
            end
            if (CW'(stg_reg[k].rem_im) >= dsh)
            begin
                stg_next[k + 1].rem_im             = stg_reg[k].rem_im - dsh[NW-1:0];
                stg_next[k + 1].quo_im[QB - 1 - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= st0_next;
            for (int k = 1; k <= QB; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= item_valid;
            vld_reg     <= {vld_reg[QB-1:0], s1_vld_reg};
            out_vld_reg <= vld_reg[QB];
        end
    end

    // Final selection and saturation into the output register.
    always_comb
    begin
        logic        f_neg_re;
        logic        f_neg_im;
        logic [32:0] f_mag_re;
        logic [32:0] f_mag_im;
        cna_part_t   p_re;
        cna_part_t   p_im;
        stage_t      s;
        s = stg_reg[QB];
        if (s.op == OP_DIV)
        begin
            f_neg_re = s.d_neg_re;
            f_neg_im = s.d_neg_im;
            f_mag_re = s.ovf_re ? 33'h1_0000_0000 : 33'(s.quo_re);
            f_mag_im = s.ovf_im ? 33'h1_0000_0000 : 33'(s.quo_im);
        end
        else
        begin
            f_neg_re = s.e_neg_re;
            f_neg_im = s.e_neg_im;
            f_mag_re = s.e_mag_re;
            f_mag_im = s.e_mag_im;
        end
        p_re = clamp_part(f_neg_re, f_mag_re);
        p_im = clamp_part(f_neg_im, f_mag_im);
        out_fin_re = p_re.val;
        out_fin_im = p_im.val;
        if (s.op == OP_DIV && s.b_zero)
        begin
            out_fin_re = '0;
            out_fin_im = '0;
            out_fin_st = ST_DIVZ;
        end
        else if (p_re.sat || p_im.sat)
        begin
            out_fin_st = ST_SAT;
        end
        else
        begin
            out_fin_st = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg <= $signed(out_fin_re);
            out_im_reg <= $signed(out_fin_im);
            out_st_reg <= out_fin_st;
        end
    end

    assign out_ch.valid  = out_vld_reg;
    assign out_ch.r_re   = out_re_reg;
    assign out_ch.r_im   = out_im_reg;
    assign out_ch.status = out_st_reg;
endmodule
`default_nettype wire

[rtl/complex_number_alu.sv]
// ----------------------------------------------------------------------------
// complex_number_alu
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
// ----------------------------------------------------------------------------
// Each transfer on in_ch carries an operation code and two complex operands
// in signed fixed point with FRAC_BITS fraction bits, and produces exactly one
// transfer on out_ch, in order. Multiply keeps the full-precision cross
// products and truncates toward zero when it scales back. Divide multiplies
// by the conjugate of b and divides by |b|^2, truncating toward zero. A part
// that leaves the signed 16-bit range is clamped and status reports
// saturation; a zero divisor returns zero parts with a divide-by-zero status.
// The block takes one transfer per cycle and returns one per cycle while
// out_ch accepts results. Every operation passes through the same stages:
// the product and sum stages, the divider, which resolves one quotient bit
// per pipeline stage over 17 stages, and the output stage. A four-entry
// queue sits between the input side and the pipeline, and the pipeline
// stalls only while a finished result waits on out_ch.
`default_nettype none
`include "assert_macros.svh"
module complex_number_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    cna_in_if.sink     in_ch,
    cna_out_if.source  out_ch
);
    import cna_pkg::*;

    // Front end hands each classified item to the queue.
    cna_item_t  push_item;
    logic       push;
    cna_qstat_t qstat;
    cna_item_t  head_item;
    logic       pop;

    // Result checks used by the assertions below.
    logic       parts_zero;
    logic       part_on_bound;

    cna_front u_front (
        .in_ch (in_ch),
        .qstat (qstat),
        .item  (push_item),
        .push  (push)
    );

    cna_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (head_item),
        .qstat   (qstat)
    );

    // Execution pipeline pulls from the queue whenever it can advance.
    cna_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .item_valid (qstat.valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );

    assign parts_zero    = (out_ch.r_re == 16'sd0) && (out_ch.r_im == 16'sd0);
    assign part_on_bound = (out_ch.r_re == 16'sh7fff) || (out_ch.r_re == 16'sh8000) ||
                           (out_ch.r_im == 16'sh7fff) || (out_ch.r_im == 16'sh8000);

    // A divide by zero must deliver zero parts.
    `CNA_ASSERT_IMP(a_divz_zero, clk, rst_n, out_ch.valid && out_ch.status == ST_DIVZ, parts_zero)
    // A saturated result has at least one part sitting on a range bound.
    `CNA_ASSERT_IMP(a_sat_bound, clk, rst_n, out_ch.valid && out_ch.status == ST_SAT, part_on_bound)
    // The queue never holds more than its depth.
    `CNA_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, qstat.count <= QCNT_W'(QDEPTH))
    // After an input transfer the queue cannot be empty.
    `CNA_ASSERT_NXT(a_q_nonempty, clk, rst_n, in_ch.valid && in_ch.ready, qstat.count != '0)
endmodule
`default_nettype wire
